// ----- src/ftp_pkg.sv -----
// Shared widths, register codes, CORDIC angle table and result type for the fisheye remap.
`default_nettype none

package ftp_pkg;

	localparam int COORD_W   = 12;
	localparam int CFG_W     = 54;
	localparam int CFG_IDX_W = 3;
	localparam int COEF_W    = 18;
	localparam int FL_W      = 16;
	localparam int HALF_W    = 12;
	localparam int VEC_W     = 17;
	localparam int PROD_W    = 35;
	localparam int SUM_W     = 37;
	localparam int XW        = 24;
	localparam int SQ_W      = 2 * XW;
	localparam int RHO_W     = 24;
	localparam int CW        = 27;
	localparam int AW        = 34;
	localparam int RW        = 24;
	localparam int NUM_W     = RW + XW;
	localparam int NW        = 46;
	localparam int DW        = RHO_W + 1;
	localparam int QW        = 24;
	localparam int OUT_W     = 24;
	localparam int BASE_W    = 21;
	localparam int SUMO_W    = 26;

	localparam int COORD_BITS_DEF    = 12;
	localparam int CORDIC_STAGES_DEF = 16;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ROT_X      = 3'd0,
		REG_ROT_Y      = 3'd1,
		REG_ROT_Z      = 3'd2,
		REG_FOCAL      = 3'd3,
		REG_FOCAL_SCL  = 3'd4,
		REG_OUT_HALF_W = 3'd5,
		REG_OUT_HALF_H = 3'd6,
		REG_IN_HALF_W  = 3'd7
	} reg_idx_t;

	localparam logic signed [AW-1:0] HALF_PI_Q30 = 34'sd1686629713;
	localparam logic signed [OUT_W-1:0] OUT_MAX = 24'sh7FFFFF;
	localparam logic signed [OUT_W-1:0] OUT_MIN = 24'sh800000;

	localparam logic [31:0] ATAN_Q30 [32] = '{
		32'd843314857, 32'd497837829, 32'd263043837, 32'd133525159, 32'd67021687,
		32'd33543516, 32'd16775851, 32'd8388437, 32'd4194283, 32'd2097149, 32'd1048576,
		32'd524288, 32'd262144, 32'd131072, 32'd65536, 32'd32768, 32'd16384, 32'd8192,
		32'd4096, 32'd2048, 32'd1024, 32'd512, 32'd256, 32'd128, 32'd64, 32'd32, 32'd16,
		32'd8, 32'd4, 32'd2, 32'd1, 32'd0
	};

	typedef struct packed {
		logic signed [OUT_W-1:0] map_x;
		logic signed [OUT_W-1:0] map_y;
		logic                    clipped;
	} map_t;

endpackage

`default_nettype wire

// ----- src/ftp_pix_if.sv -----
// Input channel: one output pixel coordinate per transfer.
`default_nettype none

interface ftp_pix_if;
	logic                          valid;
	logic                          ready;
	logic [ftp_pkg::COORD_W-1:0]   out_col;
	logic [ftp_pkg::COORD_W-1:0]   out_row;

	modport source(output valid, output out_col, output out_row, input ready);
	modport sink(input valid, input out_col, input out_row, output ready);
endinterface

`default_nettype wire

// ----- src/ftp_map_if.sv -----
// Output channel: one fisheye source coordinate pair per transfer.
`default_nettype none

interface ftp_map_if;
	logic                               valid;
	logic                               ready;
	logic signed [ftp_pkg::OUT_W-1:0]   map_x;
	logic signed [ftp_pkg::OUT_W-1:0]   map_y;
	logic                               clipped;

	modport source(output valid, output map_x, output map_y, output clipped, input ready);
	modport sink(input valid, input map_x, input map_y, input clipped, output ready);
endinterface

`default_nettype wire

// ----- src/ftp_isqrt.sv -----
// Pipelined integer square root, one result bit per stage.
`default_nettype none

module ftp_isqrt #(
	parameter int OUT_W  = ftp_pkg::RHO_W,
	parameter int SIDE_W = 1
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  en,
	input  wire logic                  in_valid,
	input  wire logic [2*OUT_W-1:0]    radicand,
	input  wire logic [SIDE_W-1:0]     side_in,
	output logic                       out_valid,
	output logic [OUT_W-1:0]           root,
	output logic [SIDE_W-1:0]          side_out
);

	localparam int IN_W = 2 * OUT_W;
	localparam int RMW  = OUT_W + 2;

	logic              v_s    [OUT_W];
	logic [RMW-1:0]    rem_s  [OUT_W];
	logic [OUT_W-1:0]  root_s [OUT_W];
	logic [IN_W-1:0]   rad_s  [OUT_W];
	logic [SIDE_W-1:0] side_s [OUT_W];

	for (genvar g = 0; g < OUT_W; g++) begin : g_stage
		logic              pv;
		logic [RMW-1:0]    prem;
		logic [OUT_W-1:0]  proot;
		logic [IN_W-1:0]   prad;
		logic [SIDE_W-1:0] pside;
		logic [RMW-1:0]    cat;
		logic [RMW-1:0]    trial;
		logic              ge;

		if (g == 0) begin : g_first
			assign pv    = in_valid;
			assign prem  = '0;
			assign proot = '0;
			assign prad  = radicand;
			assign pside = side_in;
		end else begin : g_next
			assign pv    = v_s[g-1];
			assign prem  = rem_s[g-1];
			assign proot = root_s[g-1];
			assign prad  = rad_s[g-1];
			assign pside = side_s[g-1];
		end

		// bring down the next two radicand bits, try root*4+1
		assign cat   = {prem[RMW-3:0], prad[IN_W-1 -: 2]};
		assign trial = {proot, 2'b01};
		assign ge    = (cat >= trial);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[g] <= 1'b0;
			end else if (en) begin
				v_s[g] <= pv;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[g]  <= ge ? (cat - trial) : cat;
				root_s[g] <= {proot[OUT_W-2:0], ge};
				rad_s[g]  <= {prad[IN_W-3:0], 2'b00};
				side_s[g] <= pside;
			end
		end
	end

	assign out_valid = v_s[OUT_W-1];
	assign root      = root_s[OUT_W-1];
	assign side_out  = side_s[OUT_W-1];

endmodule

`default_nettype wire

// ----- src/ftp_cordic.sv -----
// Pipelined CORDIC vectoring, one micro-rotation per stage, accumulating the angle.
`default_nettype none

module ftp_cordic #(
	parameter int STAGES = ftp_pkg::CORDIC_STAGES_DEF,
	parameter int SIDE_W = 1
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          en,
	input  wire logic                          in_valid,
	input  wire logic signed [ftp_pkg::CW-1:0] cx_in,
	input  wire logic signed [ftp_pkg::CW-1:0] cy_in,
	input  wire logic signed [ftp_pkg::AW-1:0] ang_in,
	input  wire logic [SIDE_W-1:0]             side_in,
	output logic                               out_valid,
	output logic signed [ftp_pkg::AW-1:0]      ang,
	output logic [SIDE_W-1:0]                  side_out
);

	localparam int CW = ftp_pkg::CW;
	localparam int AW = ftp_pkg::AW;

	logic                 v_s    [STAGES];
	logic signed [CW-1:0] cx_s   [STAGES];
	logic signed [CW-1:0] cy_s   [STAGES];
	logic signed [AW-1:0] ang_s  [STAGES];
	logic [SIDE_W-1:0]    side_s [STAGES];

	for (genvar g = 0; g < STAGES; g++) begin : g_stage
		logic                 pv;
		logic signed [CW-1:0] pcx;
		logic signed [CW-1:0] pcy;
		logic signed [AW-1:0] pang;
		logic [SIDE_W-1:0]    pside;
		logic signed [CW-1:0] dx;
		logic signed [CW-1:0] dy;
		logic signed [AW-1:0] at;
		logic                 pos;

		if (g == 0) begin : g_first
			assign pv    = in_valid;
			assign pcx   = cx_in;
			assign pcy   = cy_in;
			assign pang  = ang_in;
			assign pside = side_in;
		end else begin : g_next
			assign pv    = v_s[g-1];
			assign pcx   = cx_s[g-1];
			assign pcy   = cy_s[g-1];
			assign pang  = ang_s[g-1];
			assign pside = side_s[g-1];
		end

		assign dx  = pcy >>> g;
		assign dy  = pcx >>> g;
		assign at  = AW'({2'b00, ftp_pkg::ATAN_Q30[g]});
		assign pos = !pcy[CW-1] && (pcy != '0);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[g] <= 1'b0;
			end else if (en) begin
				v_s[g] <= pv;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				if (pos) begin
					cx_s[g]  <= pcx + dx;
					cy_s[g]  <= pcy - dy;
					ang_s[g] <= pang + at;
				end else begin
					cx_s[g]  <= pcx - dx;
					cy_s[g]  <= pcy + dy;
					ang_s[g] <= pang - at;
				end
				side_s[g] <= pside;
			end
		end
	end

	assign out_valid = v_s[STAGES-1];
	assign ang       = ang_s[STAGES-1];
	assign side_out  = side_s[STAGES-1];

endmodule

`default_nettype wire

// ----- src/ftp_div.sv -----
// Pipelined restoring divider, one quotient bit per stage; quotient must fit in QW bits.
`default_nettype none

module ftp_div #(
	parameter int NW     = ftp_pkg::NW,
	parameter int DW     = ftp_pkg::DW,
	parameter int QW     = ftp_pkg::QW,
	parameter int SIDE_W = 1
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              en,
	input  wire logic              in_valid,
	input  wire logic [NW-1:0]     num,
	input  wire logic [DW-1:0]     den,
	input  wire logic [SIDE_W-1:0] side_in,
	output logic                   out_valid,
	output logic [QW-1:0]          quo,
	output logic [SIDE_W-1:0]      side_out
);

	logic              v_s    [QW];
	logic [DW-1:0]     rem_s  [QW];
	logic [QW-1:0]     low_s  [QW];
	logic [QW-1:0]     q_s    [QW];
	logic [DW-1:0]     den_s  [QW];
	logic [SIDE_W-1:0] side_s [QW];

	for (genvar g = 0; g < QW; g++) begin : g_stage
		logic              pv;
		logic [DW-1:0]     prem;
		logic [QW-1:0]     plow;
		logic [QW-1:0]     pq;
		logic [DW-1:0]     pden;
		logic [SIDE_W-1:0] pside;
		logic [DW:0]       cat;
		logic [DW:0]       diff;
		logic              ge;

		if (g == 0) begin : g_first
			// upper numerator bits are already below the divisor
			assign pv    = in_valid;
			assign prem  = DW'(num[NW-1:QW]);
			assign plow  = num[QW-1:0];
			assign pq    = '0;
			assign pden  = den;
			assign pside = side_in;
		end else begin : g_next
			assign pv    = v_s[g-1];
			assign prem  = rem_s[g-1];
			assign plow  = low_s[g-1];
			assign pq    = q_s[g-1];
			assign pden  = den_s[g-1];
			assign pside = side_s[g-1];
		end

		assign cat  = {prem, plow[QW-1]};
		assign diff = cat - {1'b0, pden};
		assign ge   = (cat >= {1'b0, pden});

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[g] <= 1'b0;
			end else if (en) begin
				v_s[g] <= pv;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[g]  <= ge ? diff[DW-1:0] : cat[DW-1:0];
				low_s[g]  <= {plow[QW-2:0], 1'b0};
				q_s[g]    <= {pq[QW-2:0], ge};
				den_s[g]  <= pden;
				side_s[g] <= pside;
			end
		end
	end

	assign out_valid = v_s[QW-1];
	assign quo       = q_s[QW-1];
	assign side_out  = side_s[QW-1];

endmodule

`default_nettype wire

// ----- src/fisheye_to_perspective_map_top.sv -----
// Top level of the fisheye-to-perspective coordinate map pipeline.
`default_nettype none

// Maps each output pixel (out_col, out_row) of a rectilinear view to a signed
// Q15.8 source point in an equidistant fisheye image. One pixel is accepted
// per clock while the skid entry is empty; the path runs through
// 5 rotate/square stages, 24 square-root stages, CORDIC_STAGES angle stages,
// 3 radius/product stages, 24 divider stages and one output register. The
// output register has one skid entry behind it, so one more pixel is taken
// while a result waits; the pipeline then holds until the sink drains it.
// Configuration registers must only be written while the pipeline is empty.
module fisheye_to_perspective_map_top #(
	parameter int COORD_BITS    = ftp_pkg::COORD_BITS_DEF,
	parameter int CORDIC_STAGES = ftp_pkg::CORDIC_STAGES_DEF
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           cfg_we,
	input  wire logic [ftp_pkg::CFG_IDX_W-1:0]  cfg_idx,
	input  wire logic [ftp_pkg::CFG_W-1:0]      cfg_wdata,
	ftp_pix_if.sink                             pix,
	ftp_map_if.source                           map
);

	localparam int COORD_W = ftp_pkg::COORD_W;
	localparam int COEF_W  = ftp_pkg::COEF_W;
	localparam int VEC_W   = ftp_pkg::VEC_W;
	localparam int PROD_W  = ftp_pkg::PROD_W;
	localparam int SUM_W   = ftp_pkg::SUM_W;
	localparam int XW      = ftp_pkg::XW;
	localparam int SQ_W    = ftp_pkg::SQ_W;
	localparam int RHO_W   = ftp_pkg::RHO_W;
	localparam int CW      = ftp_pkg::CW;
	localparam int AW      = ftp_pkg::AW;
	localparam int RW      = ftp_pkg::RW;
	localparam int NUM_W   = ftp_pkg::NUM_W;
	localparam int NW      = ftp_pkg::NW;
	localparam int DW      = ftp_pkg::DW;
	localparam int QW      = ftp_pkg::QW;
	localparam int BASE_W  = ftp_pkg::BASE_W;
	localparam int SUMO_W  = ftp_pkg::SUMO_W;
	localparam int PW      = 52;
	localparam logic [COORD_W-1:0] CMASK = (COORD_BITS >= COORD_W) ?
		{COORD_W{1'b1}} : COORD_W'((1 << COORD_BITS) - 1);

	// ---------------- configuration ----------------
	logic [ftp_pkg::CFG_W-1:0]  rot_q [3];
	logic [ftp_pkg::FL_W-1:0]   focal_q;
	logic [ftp_pkg::FL_W-1:0]   fos_q;
	logic [ftp_pkg::HALF_W-1:0] ohw_q;
	logic [ftp_pkg::HALF_W-1:0] ohh_q;
	logic [ftp_pkg::HALF_W-1:0] ihw_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rot_q[0] <= 54'd65536;
			rot_q[1] <= 54'd65536 << 18;
			rot_q[2] <= 54'd65536 << 36;
			focal_q  <= 16'd5215;
			fos_q    <= 16'd5215;
			ohw_q    <= 12'd320;
			ohh_q    <= 12'd240;
			ihw_q    <= 12'd512;
		end else if (cfg_we) begin
			case (ftp_pkg::reg_idx_t'(cfg_idx))
				ftp_pkg::REG_ROT_X:      rot_q[0] <= cfg_wdata;
				ftp_pkg::REG_ROT_Y:      rot_q[1] <= cfg_wdata;
				ftp_pkg::REG_ROT_Z:      rot_q[2] <= cfg_wdata;
				ftp_pkg::REG_FOCAL:      focal_q  <= cfg_wdata[ftp_pkg::FL_W-1:0];
				ftp_pkg::REG_FOCAL_SCL:  fos_q    <= cfg_wdata[ftp_pkg::FL_W-1:0];
				ftp_pkg::REG_OUT_HALF_W: ohw_q    <= cfg_wdata[ftp_pkg::HALF_W-1:0];
				ftp_pkg::REG_OUT_HALF_H: ohh_q    <= cfg_wdata[ftp_pkg::HALF_W-1:0];
				ftp_pkg::REG_IN_HALF_W:  ihw_q    <= cfg_wdata[ftp_pkg::HALF_W-1:0];
				default: ;
			endcase
		end
	end

	// ---------------- flow control ----------------
	logic en;
	logic skid_v_q;
	logic out_v_q;

	assign en        = !skid_v_q;
	assign pix.ready = en;

	// ---------------- s1: centered view vector, Q.4 ----------------
	logic                    v_s1;
	logic signed [VEC_W-1:0] vec_s1 [3];
	logic [COORD_W-1:0]      col;
	logic [COORD_W-1:0]      row;
	logic signed [COORD_W:0] dcol;
	logic signed [COORD_W:0] drow;

	assign col  = pix.out_col & CMASK;
	assign row  = pix.out_row & CMASK;
	assign dcol = $signed({1'b0, col}) - $signed({1'b0, ohw_q});
	assign drow = $signed({1'b0, row}) - $signed({1'b0, ohh_q});

	always_ff @(posedge clk) begin
		if (en) begin
			vec_s1[0] <= {dcol, 4'b0000};
			vec_s1[1] <= {drow, 4'b0000};
			vec_s1[2] <= $signed({1'b0, focal_q});
		end
	end

	// ---------------- s2: nine coefficient products ----------------
	logic                     v_s2;
	logic signed [PROD_W-1:0] p_s2 [3][3];
	logic signed [COEF_W-1:0] coef [3][3];

	for (genvar i = 0; i < 3; i++) begin : g_coef_row
		for (genvar j = 0; j < 3; j++) begin : g_coef
			assign coef[i][j] = $signed(rot_q[i][COEF_W*j +: COEF_W]);

			always_ff @(posedge clk) begin
				if (en) begin
					p_s2[i][j] <= coef[i][j] * vec_s1[j];
				end
			end
		end
	end

	// ---------------- s3: row sums rounded to Q.8 ----------------
	logic                  v_s3;
	logic signed [XW-1:0]  xyz_s3 [3];
	logic signed [SUM_W-1:0] rsum [3];
	logic signed [SUM_W-1:0] rshf [3];

	for (genvar i = 0; i < 3; i++) begin : g_rowsum
		assign rsum[i] = SUM_W'(p_s2[i][0]) + SUM_W'(p_s2[i][1]) + SUM_W'(p_s2[i][2])
			+ SUM_W'(2048);
		assign rshf[i] = rsum[i] >>> 12;

		always_ff @(posedge clk) begin
			if (en) begin
				xyz_s3[i] <= rshf[i][XW-1:0];
			end
		end
	end

	// ---------------- s4/s5: squared length in the image plane ----------------
	logic                   v_s4;
	logic                   v_s5;
	logic signed [SQ_W-1:0] xx_s4;
	logic signed [SQ_W-1:0] yy_s4;
	logic signed [XW-1:0]   xyz_s4 [3];
	logic [SQ_W-1:0]        sq_s5;
	logic signed [XW-1:0]   xyz_s5 [3];

	always_ff @(posedge clk) begin
		if (en) begin
			xx_s4  <= xyz_s3[0] * xyz_s3[0];
			yy_s4  <= xyz_s3[1] * xyz_s3[1];
			xyz_s4 <= xyz_s3;
			sq_s5  <= xx_s4 + yy_s4;
			xyz_s5 <= xyz_s4;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else if (en) begin
			v_s1 <= pix.valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	// ---------------- rho = floor(sqrt(x*x + y*y)) ----------------
	logic                 sq_v;
	logic [RHO_W-1:0]     sq_rho;
	logic [3*XW-1:0]      sq_side;
	logic signed [XW-1:0] sq_x;
	logic signed [XW-1:0] sq_y;
	logic signed [XW-1:0] sq_z;

	ftp_isqrt #(
		.OUT_W (RHO_W),
		.SIDE_W(3 * XW)
	) u_isqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (v_s5),
		.radicand (sq_s5),
		.side_in  ({xyz_s5[0], xyz_s5[1], xyz_s5[2]}),
		.out_valid(sq_v),
		.root     (sq_rho),
		.side_out (sq_side)
	);

	assign {sq_x, sq_y, sq_z} = sq_side;

	// ---------------- phi = atan2(rho, z) ----------------
	logic signed [CW-1:0] c_cx;
	logic signed [CW-1:0] c_cy;
	logic signed [AW-1:0] c_ang;
	logic signed [CW-1:0] z_ext;
	logic signed [CW-1:0] rho_ext;

	assign z_ext   = CW'(sq_z);
	assign rho_ext = CW'({1'b0, sq_rho});

	// a vector behind the view plane is pre-turned by -pi/2
	always_comb begin
		if (sq_z < 0) begin
			c_cx  = rho_ext;
			c_cy  = -z_ext;
			c_ang = ftp_pkg::HALF_PI_Q30;
		end else begin
			c_cx  = z_ext;
			c_cy  = rho_ext;
			c_ang = '0;
		end
	end

	logic                 co_v;
	logic signed [AW-1:0] co_ang;
	logic [2*XW+RHO_W-1:0] co_side;
	logic signed [XW-1:0] co_x;
	logic signed [XW-1:0] co_y;
	logic [RHO_W-1:0]     co_rho;

	ftp_cordic #(
		.STAGES(CORDIC_STAGES),
		.SIDE_W(2 * XW + RHO_W)
	) u_cordic (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (sq_v),
		.cx_in    (c_cx),
		.cy_in    (c_cy),
		.ang_in   (c_ang),
		.side_in  ({sq_x, sq_y, sq_rho}),
		.out_valid(co_v),
		.ang      (co_ang),
		.side_out (co_side)
	);

	assign {co_x, co_y, co_rho} = co_side;

	// ---------------- s6/s7: r = focal_over_scale * phi, Q.8 ----------------
	logic                  v_s6;
	logic [32:0]           plo_s6;
	logic signed [33:0]    phi_s6;
	logic signed [XW-1:0]  x_s6;
	logic signed [XW-1:0]  y_s6;
	logic [RHO_W-1:0]      rho_s6;

	logic                  v_s7;
	logic signed [RW-1:0]  r_s7;
	logic signed [XW-1:0]  x_s7;
	logic signed [XW-1:0]  y_s7;
	logic [RHO_W-1:0]      rho_s7;
	logic signed [PW-1:0]  rprod;
	logic signed [PW-1:0]  rshift;

	assign rprod  = (PW'(phi_s6) <<< 17) + PW'($signed({1'b0, plo_s6})) + PW'(33554432);
	assign rshift = rprod >>> 26;

	// ---------------- s8: r*x and r*y ----------------
	logic                    v_s8;
	logic signed [NUM_W-1:0] nx_s8;
	logic signed [NUM_W-1:0] ny_s8;
	logic signed [RW-1:0]    r_s8;
	logic [RHO_W-1:0]        rho_s8;

	always_ff @(posedge clk) begin
		if (en) begin
			plo_s6 <= fos_q * co_ang[16:0];
			phi_s6 <= $signed({1'b0, fos_q}) * $signed(co_ang[AW-1:17]);
			x_s6   <= co_x;
			y_s6   <= co_y;
			rho_s6 <= co_rho;
			r_s7   <= rshift[RW-1:0];
			x_s7   <= x_s6;
			y_s7   <= y_s6;
			rho_s7 <= rho_s6;
			nx_s8  <= r_s7 * x_s7;
			ny_s8  <= r_s7 * y_s7;
			r_s8   <= r_s7;
			rho_s8 <= rho_s7;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
			v_s8 <= 1'b0;
		end else if (en) begin
			v_s6 <= co_v;
			v_s7 <= v_s6;
			v_s8 <= v_s7;
		end
	end

	// ---------------- rounded division by rho ----------------
	logic [NUM_W-1:0] magx;
	logic [NUM_W-1:0] magy;
	logic [NW-1:0]    numx;
	logic [NW-1:0]    numy;
	logic [DW-1:0]    den;

	assign magx = nx_s8[NUM_W-1] ? NUM_W'(-nx_s8) : NUM_W'(nx_s8);
	assign magy = ny_s8[NUM_W-1] ? NUM_W'(-ny_s8) : NUM_W'(ny_s8);
	// (2|n| + rho) / (2 rho) rounds half away from zero
	assign numx = {magx[NW-2:0], 1'b0} + NW'(rho_s8);
	assign numy = {magy[NW-2:0], 1'b0} + NW'(rho_s8);
	assign den  = {rho_s8, 1'b0};

	logic                  dx_v;
	logic [QW-1:0]         qx;
	logic [QW-1:0]         qy;
	logic [RW+1:0]         dx_side;
	logic                  dy_side;
	logic                  dy_v;
	logic signed [RW-1:0]  d_r;
	logic                  d_rho0;
	logic                  d_sx;

	ftp_div #(
		.NW    (NW),
		.DW    (DW),
		.QW    (QW),
		.SIDE_W(RW + 2)
	) u_div_x (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (v_s8),
		.num      (numx),
		.den      (den),
		.side_in  ({r_s8, (rho_s8 == '0), nx_s8[NUM_W-1]}),
		.out_valid(dx_v),
		.quo      (qx),
		.side_out (dx_side)
	);

	ftp_div #(
		.NW    (NW),
		.DW    (DW),
		.QW    (QW),
		.SIDE_W(1)
	) u_div_y (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (v_s8),
		.num      (numy),
		.den      (den),
		.side_in  (ny_s8[NUM_W-1]),
		.out_valid(dy_v),
		.quo      (qy),
		.side_out (dy_side)
	);

	assign {d_r, d_rho0, d_sx} = dx_side;

	// ---------------- offset, centre and saturate ----------------
	logic signed [QW:0]       sqx;
	logic signed [QW:0]       sqy;
	logic signed [QW:0]       offx;
	logic signed [QW:0]       offy;
	logic signed [BASE_W-1:0] base;
	logic signed [SUMO_W-1:0] sumx;
	logic signed [SUMO_W-1:0] sumy;
	logic                     satx;
	logic                     saty;
	ftp_pkg::map_t            res;

	assign sqx  = $signed({1'b0, qx});
	assign sqy  = $signed({1'b0, qy});
	assign offx = d_rho0 ? (QW+1)'(d_r) : (d_sx ? -sqx : sqx);
	assign offy = d_rho0 ? '0 : (dy_side ? -sqy : sqy);
	assign base = $signed({1'b0, ihw_q, 8'h00}) - BASE_W'(128);
	assign sumx = SUMO_W'(offx) + SUMO_W'(base);
	assign sumy = SUMO_W'(offy) + SUMO_W'(base);

	always_comb begin
		satx = 1'b1;
		saty = 1'b1;
		if (sumx > SUMO_W'(ftp_pkg::OUT_MAX)) begin
			res.map_x = ftp_pkg::OUT_MAX;
		end else if (sumx < SUMO_W'(ftp_pkg::OUT_MIN)) begin
			res.map_x = ftp_pkg::OUT_MIN;
		end else begin
			res.map_x = sumx[ftp_pkg::OUT_W-1:0];
			satx      = 1'b0;
		end
		if (sumy > SUMO_W'(ftp_pkg::OUT_MAX)) begin
			res.map_y = ftp_pkg::OUT_MAX;
		end else if (sumy < SUMO_W'(ftp_pkg::OUT_MIN)) begin
			res.map_y = ftp_pkg::OUT_MIN;
		end else begin
			res.map_y = sumy[ftp_pkg::OUT_W-1:0];
			saty      = 1'b0;
		end
		res.clipped = satx | saty;
	end

	// ---------------- output register with one skid entry ----------------
	ftp_pkg::map_t out_d_q;
	ftp_pkg::map_t skid_d_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (en) begin
			if (out_v_q && !map.ready) begin
				skid_v_q <= dx_v;
			end else begin
				out_v_q <= dx_v;
			end
		end else if (map.ready) begin
			skid_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (out_v_q && !map.ready) begin
				skid_d_q <= res;
			end else begin
				out_d_q <= res;
			end
		end else if (map.ready) begin
			out_d_q <= skid_d_q;
		end
	end

	assign map.valid   = out_v_q;
	assign map.map_x   = out_d_q.map_x;
	assign map.map_y   = out_d_q.map_y;
	assign map.clipped = out_d_q.clipped;

	// ---------------- checks ----------------
	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_v_q |-> out_v_q)
		else $error("skid entry holds a result while the output register is empty");

	a_skid_fill: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(skid_v_q) |-> $past(out_v_q && !map.ready))
		else $error("skid entry filled without an output stall");

	a_div_lockstep: assert property (@(posedge clk) disable iff (!arst_n)
		dx_v == dy_v)
		else $error("x and y dividers out of step");

	a_clip_flag: assert property (@(posedge clk) disable iff (!arst_n)
		(map.valid && map.clipped) |-> (map.map_x == ftp_pkg::OUT_MAX
		|| map.map_x == ftp_pkg::OUT_MIN || map.map_y == ftp_pkg::OUT_MAX
		|| map.map_y == ftp_pkg::OUT_MIN))
		else $error("clipped flag set on an unsaturated result");

endmodule

`default_nettype wire
